/* hw/rtl/fmme_pkg.sv */
package fmme_pkg;

  localparam int unsigned DISP_W  = 12;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned BOUND_W = 12;
  localparam int unsigned CNT_OUT_W = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned BOX_W = 28;
  localparam int unsigned MAG_W = 24;
  localparam int unsigned CMP_W = 33;

  localparam logic [CFG_IDX_W-1:0] REG_SHAKE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd3;

  localparam logic [THR_W-1:0]   RST_SHAKE = 8'd30;
  localparam logic [BOUND_W-1:0] RST_LEFT  = 12'd40;
  localparam logic [BOUND_W-1:0] RST_RIGHT = 12'd120;
  localparam logic [BOUND_W-1:0] RST_TOP   = 12'd20;

  localparam logic [DISP_W-1:0] SIGN_FLIP = 12'h800;

  typedef struct packed {
    logic [DISP_W-1:0] dx;
    logic [DISP_W-1:0] dy;
    logic              keep;
    logic              last;
  } item_t;

endpackage

/* hw/rtl/fmme_fifo.sv */
module fmme_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fmme_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output fmme_pkg::item_t rdata,
  output logic           empty
);
  import fmme_pkg::*;

  item_t       mem_r [4];
  logic [1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 2'd1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + 3'(do_push) - 3'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

/* hw/rtl/fmme_front.sv */
module fmme_front #(
  parameter int unsigned FRACTION_BITS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [fmme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fmme_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [fmme_pkg::POS_W-1:0]           in_start_x,
  input  logic [fmme_pkg::POS_W-1:0]           in_start_y,
  input  logic signed [fmme_pkg::DISP_W-1:0]   in_disp_x,
  input  logic signed [fmme_pkg::DISP_W-1:0]   in_disp_y,
  input  logic                                 in_tracked,
  input  logic                                 in_last,
  input  logic                                 in_push,
  input  logic                                 q_full,
  output logic                                 q_push,
  output fmme_pkg::item_t                      q_item
);
  import fmme_pkg::*;

  localparam int unsigned LIM_W = THR_W + FRACTION_BITS;
  localparam int unsigned LSQ_W = 2 * LIM_W;
  localparam logic [LIM_W-1:0] RST_LIM = LIM_W'(RST_SHAKE) << FRACTION_BITS;

  logic [BOUND_W-1:0] left_r, right_r, top_r;
  logic [LIM_W-1:0]   lim;
  logic [LSQ_W-1:0]   lsq_r, lsq_nxt;
  logic signed [2*DISP_W-1:0] sqx, sqy;
  logic [MAG_W-1:0]   mag;
  logic               shake_ok, central, keep;

  assign lim     = LIM_W'(cfg_data[THR_W-1:0]) << FRACTION_BITS;
  assign lsq_nxt = LSQ_W'(lim) * LSQ_W'(lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= RST_LEFT;
      right_r <= RST_RIGHT;
      top_r   <= RST_TOP;
      lsq_r   <= LSQ_W'(RST_LIM) * LSQ_W'(RST_LIM);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SHAKE: lsq_r   <= lsq_nxt;
          REG_LEFT:  left_r  <= cfg_data;
          REG_RIGHT: right_r <= cfg_data;
          REG_TOP:   top_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign sqx = in_disp_x * in_disp_x;
  assign sqy = in_disp_y * in_disp_y;
  assign mag = MAG_W'($unsigned(sqx)) + MAG_W'($unsigned(sqy));
  assign shake_ok = CMP_W'(mag) < CMP_W'(lsq_r);

  assign central = (BOX_W'(in_start_x) > (BOX_W'(left_r) << FRACTION_BITS))
                && (BOX_W'(in_start_x) < (BOX_W'(right_r) << FRACTION_BITS))
                && (BOX_W'(in_start_y) > (BOX_W'(top_r) << FRACTION_BITS));

  assign keep = in_tracked && shake_ok && !central;

  assign q_item.dx   = in_disp_x;
  assign q_item.dy   = in_disp_y;
  assign q_item.keep = keep;
  assign q_item.last = in_last;
  assign q_push      = in_push && !q_full && (keep || in_last);

endmodule

/* hw/rtl/fmme_back.sv */
module fmme_back #(
  parameter int unsigned MAX_FEATURES = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fmme_pkg::item_t                     q_item,
  input  logic                                q_empty,
  output logic                                q_pop,
  output logic signed [fmme_pkg::DISP_W-1:0]  out_shift_x,
  output logic signed [fmme_pkg::DISP_W-1:0]  out_shift_y,
  output logic [fmme_pkg::CNT_OUT_W-1:0]      out_kept_count,
  output logic                                out_any_kept,
  output logic                                out_empty,
  input  logic                                out_pop
);
  import fmme_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FEATURES);
  localparam int unsigned CW = $clog2(MAX_FEATURES + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_STEP = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [DISP_W-1:0] mem_x [MAX_FEATURES];
  logic [DISP_W-1:0] mem_y [MAX_FEATURES];
  logic [DISP_W-1:0] rd_x_r, rd_y_r;
  logic              rd_en;
  logic [CW-1:0]     cnt_r, cnt_nxt, n_r, n_nxt, idx_r, idx_nxt;
  logic [CW-1:0]     ltx_r, ltx_nxt, lty_r, lty_nxt, k;
  logic [DISP_W-1:0] resx_r, resx_nxt, resy_r, resy_nxt, bit_r, bit_nxt;
  logic [DISP_W-1:0] candx, candy;
  logic              rdv_r, rdv_nxt, wr_en;
  logic              ovld_r, ovld_nxt;
  logic [DISP_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [CW+CNT_OUT_W-1:0] n_ext;
  logic [CNT_OUT_W-1:0] oc_r, oc_nxt;
  logic              oa_r, oa_nxt;

  assign k     = n_r >> 1;
  assign candx = resx_r | bit_r;
  assign candy = resy_r | bit_r;
  assign n_ext = (CW+CNT_OUT_W)'(n_r);
  assign q_pop = (state_r == ST_IDLE) && !q_empty;
  assign wr_en = q_pop && q_item.keep && (cnt_r < CW'(MAX_FEATURES));
  assign rd_en = (state_r == ST_SCAN) && (idx_r < n_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    ltx_nxt   = ltx_r;
    lty_nxt   = lty_r;
    resx_nxt  = resx_r;
    resy_nxt  = resy_r;
    bit_nxt   = bit_r;
    rdv_nxt   = 1'b0;
    ovld_nxt  = ovld_r && !out_pop;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oc_nxt    = oc_r;
    oa_nxt    = oa_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          if (wr_en) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          if (q_item.last) begin
            n_nxt    = cnt_nxt;
            idx_nxt  = '0;
            ltx_nxt  = '0;
            lty_nxt  = '0;
            resx_nxt = '0;
            resy_nxt = '0;
            bit_nxt  = SIGN_FLIP;
            state_nxt = (cnt_nxt == '0) ? ST_FIN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rdv_r) begin
          ltx_nxt = ltx_r + CW'((rd_x_r ^ SIGN_FLIP) < candx);
          lty_nxt = lty_r + CW'((rd_y_r ^ SIGN_FLIP) < candy);
        end
        if (idx_r == n_r) begin
          state_nxt = ST_STEP;
        end else begin
          idx_nxt = idx_r + CW'(1);
          rdv_nxt = 1'b1;
        end
      end
      ST_STEP: begin
        if (ltx_r <= k) resx_nxt = candx;
        if (lty_r <= k) resy_nxt = candy;
        ltx_nxt = '0;
        lty_nxt = '0;
        idx_nxt = '0;
        bit_nxt = bit_r >> 1;
        state_nxt = bit_r[0] ? ST_FIN : ST_SCAN;
      end
      ST_FIN: begin
        if (!ovld_r || out_pop) begin
          ovld_nxt  = 1'b1;
          ox_nxt    = (n_r == '0) ? '0 : resx_r ^ SIGN_FLIP;
          oy_nxt    = (n_r == '0) ? '0 : resy_r ^ SIGN_FLIP;
          oc_nxt    = n_ext[CNT_OUT_W-1:0];
          oa_nxt    = (n_r != '0);
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rdv_r   <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rdv_r   <= rdv_nxt;
      ovld_r  <= ovld_nxt;
    end
    n_r    <= n_nxt;
    idx_r  <= idx_nxt;
    ltx_r  <= ltx_nxt;
    lty_r  <= lty_nxt;
    resx_r <= resx_nxt;
    resy_r <= resy_nxt;
    bit_r  <= bit_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    oc_r   <= oc_nxt;
    oa_r   <= oa_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[cnt_r[AW-1:0]] <= q_item.dx;
      mem_y[cnt_r[AW-1:0]] <= q_item.dy;
    end
    if (rd_en) begin
      rd_x_r <= mem_x[idx_r[AW-1:0]];
      rd_y_r <= mem_y[idx_r[AW-1:0]];
    end
  end

  assign out_empty      = !ovld_r;
  assign out_shift_x    = ox_r;
  assign out_shift_y    = oy_r;
  assign out_kept_count = oc_r;
  assign out_any_kept   = oa_r;

endmodule

/* hw/rtl/filtered_median_motion_estimator.sv */
// Features enter at one per cycle; filtering is combinational, kept ones are stored
// one per cycle from a four-entry queue.
// The item marked last starts a median search: 12 passes over the n stored
// features, one per result bit, each a scan followed by a step.
// Input stalls only when the queue fills during the search or while a result waits.
// Synchronous active-low reset restores register defaults and empties the store.
module filtered_median_motion_estimator #(
  parameter int unsigned MAX_FEATURES  = 512,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fmme_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fmme_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [fmme_pkg::POS_W-1:0]          in_start_x,
  input  logic [fmme_pkg::POS_W-1:0]          in_start_y,
  input  logic signed [fmme_pkg::DISP_W-1:0]  in_disp_x,
  input  logic signed [fmme_pkg::DISP_W-1:0]  in_disp_y,
  input  logic                                in_tracked,
  input  logic                                in_last,
  input  logic                                push,
  output logic                                full,
  output logic signed [fmme_pkg::DISP_W-1:0]  out_shift_x,
  output logic signed [fmme_pkg::DISP_W-1:0]  out_shift_y,
  output logic [fmme_pkg::CNT_OUT_W-1:0]      out_kept_count,
  output logic                                out_any_kept,
  output logic                                empty,
  input  logic                                pop
);
  import fmme_pkg::*;

  item_t f_item, b_item;
  logic  f_push, q_full, q_empty, q_pop;

  fmme_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_disp_x  (in_disp_x),
    .in_disp_y  (in_disp_y),
    .in_tracked (in_tracked),
    .in_last    (in_last),
    .in_push    (push),
    .q_full     (q_full),
    .q_push     (f_push),
    .q_item     (f_item)
  );

  fmme_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (b_item),
    .empty (q_empty)
  );

  fmme_back #(.MAX_FEATURES(MAX_FEATURES)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_item         (b_item),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_shift_x    (out_shift_x),
    .out_shift_y    (out_shift_y),
    .out_kept_count (out_kept_count),
    .out_any_kept   (out_any_kept),
    .out_empty      (empty),
    .out_pop        (pop)
  );

  assign full = q_full;

endmodule
